FILE: rtl/windowed_throughput_rate_core_macros.svh
// Assertion macros used by the checker file.
`ifndef WINDOWED_THROUGHPUT_RATE_CORE_MACROS_SVH
`define WINDOWED_THROUGHPUT_RATE_CORE_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define WTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WTR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wtr_pkg.sv
package wtr_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd500000000;
  localparam logic [31:0] TICK_MUL = 32'd4398;

  localparam int TIME_W  = 64;
  localparam int TOTAL_W = 48;
  localparam int BYTES_W = 32;
  localparam int TICKS_W = 32;
  localparam int BSUM_W  = 40;
  localparam int RATE_W  = 32;
  localparam int DIV_CNT_W = $clog2(BSUM_W + 1);

  typedef logic [3:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_DT     = 4'd2,
    OP_MUL_LO = 4'd3,
    OP_MUL_HI = 4'd4,
    OP_SUM    = 4'd5,
    OP_DIV    = 4'd6,
    OP_UPDATE = 4'd7,
    OP_EMIT   = 4'd8,
    OP_FIRST  = 4'd9,
    OP_SKIP   = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_GOTO     = 3'd1,
    C_WAIT_IN  = 3'd2,
    C_IF_NEW   = 3'd3,
    C_IF_LE    = 3'd4,
    C_WAIT_DIV = 3'd5,
    C_WAIT_OUT = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic in_acc;
    logic started;
    logic le;
    logic div_done;
    logic out_free;
  } stat_t;

  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_DT    = 4'd1;
  localparam pc_t PC_CMP   = 4'd2;
  localparam pc_t PC_MULHI = 4'd3;
  localparam pc_t PC_SUM   = 4'd4;
  localparam pc_t PC_DIV   = 4'd5;
  localparam pc_t PC_DIVW  = 4'd6;
  localparam pc_t PC_UPD   = 4'd7;
  localparam pc_t PC_EMIT  = 4'd8;
  localparam pc_t PC_FIRST = 4'd9;
  localparam pc_t PC_SKIP  = 4'd10;

  // Microcode program, one control word per step.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_GOTO, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,   cond: C_WAIT_IN,  target: PC_IDLE};
      PC_DT:    w = '{op: OP_DT,     cond: C_IF_NEW,   target: PC_FIRST};
      PC_CMP:   w = '{op: OP_MUL_LO, cond: C_IF_LE,    target: PC_SKIP};
      PC_MULHI: w = '{op: OP_MUL_HI, cond: C_NEXT,     target: PC_IDLE};
      PC_SUM:   w = '{op: OP_SUM,    cond: C_NEXT,     target: PC_IDLE};
      PC_DIV:   w = '{op: OP_DIV,    cond: C_NEXT,     target: PC_IDLE};
      PC_DIVW:  w = '{op: OP_NOP,    cond: C_WAIT_DIV, target: PC_IDLE};
      PC_UPD:   w = '{op: OP_UPDATE, cond: C_NEXT,     target: PC_IDLE};
      PC_EMIT:  w = '{op: OP_EMIT,   cond: C_WAIT_OUT, target: PC_IDLE};
      PC_FIRST: w = '{op: OP_FIRST,  cond: C_NEXT,     target: PC_IDLE};
      PC_SKIP:  w = '{op: OP_SKIP,   cond: C_WAIT_OUT, target: PC_IDLE};
      default:  w = '{op: OP_NOP,    cond: C_GOTO,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/wtr_div.sv
module wtr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wtr_pkg::BSUM_W-1:0]  dividend,
  input  logic [wtr_pkg::TICKS_W-1:0] divisor,
  output logic                        busy,
  output logic [wtr_pkg::BSUM_W-1:0]  quotient
);
  import wtr_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [BSUM_W-1:0]    quo_r;
  logic [TICKS_W:0]     rem_r;
  logic [TICKS_W-1:0]   dvs_r;
  logic [TICKS_W:0]     rem_sh;
  logic [TICKS_W+1:0]   diff;
  logic                 ge;

  // Restoring divide, one quotient bit per cycle.
  assign rem_sh = {rem_r[TICKS_W-1:0], quo_r[BSUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = ~diff[TICKS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(BSUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[BSUM_W-2:0], ge};
      rem_r <= ge ? diff[TICKS_W:0] : rem_sh;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/wtr_seq.sv
module wtr_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  wtr_pkg::stat_t stat,
  output wtr_pkg::op_t   op
);
  import wtr_pkg::*;

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t uw;

  assign uw = ucode_rom(pc_r);
  assign op = uw.op;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     pc_nxt = pc_r + 1'b1;
      C_GOTO:     pc_nxt = uw.target;
      C_WAIT_IN:  pc_nxt = stat.in_acc ? pc_r + 1'b1 : pc_r;
      C_IF_NEW:   pc_nxt = !stat.started ? uw.target : pc_r + 1'b1;
      C_IF_LE:    pc_nxt = stat.le ? uw.target : pc_r + 1'b1;
      C_WAIT_DIV: pc_nxt = stat.div_done ? pc_r + 1'b1 : pc_r;
      C_WAIT_OUT: pc_nxt = stat.out_free ? uw.target : pc_r;
      default:    pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/wtr_dp.sv
module wtr_dp #(
  parameter int WINDOW_DEPTH = wtr_pkg::WINDOW_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wtr_pkg::op_t   op,
  output wtr_pkg::stat_t stat,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [111:0]   in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_tdata,
  output logic           out_tuser,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import wtr_pkg::*;

  localparam int PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic [31:0]         min_ivl_r;
  logic [TIME_W-1:0]   now_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                started_r;
  logic [TIME_W-1:0]   prev_time_r;
  logic [TOTAL_W-1:0]  prev_total_r;
  logic [TIME_W-1:0]   dt_r;
  logic [12:0]         plo_hi_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [TICKS_W-1:0]  ticks_r;
  logic [BSUM_W-1:0]   wbs_r;
  logic [TICKS_W-1:0]  wts_r;
  logic [PosW-1:0]     pos_r;
  logic [WINDOW_DEPTH-1:0] vld_r;
  logic [BYTES_W-1:0]  rd_bytes_r;
  logic [TICKS_W-1:0]  rd_ticks_r;
  logic                rd_vld_r;
  logic [RATE_W-1:0]   rate_r;
  logic                out_valid_r;
  logic                out_flag_r;
  logic [RATE_W-1:0]   out_rate_r;

  logic [BYTES_W-1:0]  ring_bytes_mem [WINDOW_DEPTH];
  logic [TICKS_W-1:0]  ring_ticks_mem [WINDOW_DEPTH];

  logic                in_acc;
  logic                out_free;
  logic                emit_go;
  logic [44:0]         mul_lo;
  logic [31:0]         mul_hi;
  logic [BYTES_W-1:0]  old_bytes;
  logic [TICKS_W-1:0]  old_ticks;
  logic                div_busy;
  logic [BSUM_W-1:0]   div_quo;

  assign in_tready = (op == OP_LOAD);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = ((op == OP_EMIT) || (op == OP_SKIP)) && out_free;

  // ticks = bits [63:32] of dt*4398, split into a low and a high partial product
  assign mul_lo = {13'd0, dt_r[31:0]} * {13'd0, TICK_MUL};
  assign mul_hi = dt_r[63:32] * TICK_MUL;

  assign old_bytes = rd_vld_r ? rd_bytes_r : '0;
  assign old_ticks = rd_vld_r ? rd_ticks_r : '0;

  assign stat.in_acc   = in_acc;
  assign stat.started  = started_r;
  assign stat.le       = (dt_r[63:32] == 32'd0) && (dt_r[31:0] <= min_ivl_r);
  assign stat.div_done = !div_busy;
  assign stat.out_free = out_free;

  wtr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_DIV),
    .dividend (wbs_r),
    .divisor  (wts_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ivl_r <= MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      min_ivl_r <= cfg_wdata;
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      prev_time_r  <= '0;
      prev_total_r <= '0;
      wbs_r        <= '0;
      wts_r        <= '0;
      pos_r        <= '0;
      vld_r        <= '0;
    end else begin
      unique case (op)
        OP_FIRST: begin
          started_r    <= 1'b1;
          prev_time_r  <= now_r;
          prev_total_r <= total_r;
        end
        OP_MUL_HI: begin
          prev_time_r  <= now_r;
          prev_total_r <= total_r;
        end
        OP_SUM: begin
          wbs_r <= wbs_r + {{(BSUM_W-BYTES_W){1'b0}}, bytes_r};
          wts_r <= wts_r + ticks_r;
        end
        OP_UPDATE: begin
          wbs_r <= wbs_r - {{(BSUM_W-BYTES_W){1'b0}}, old_bytes};
          wts_r <= wts_r - old_ticks;
          vld_r[pos_r] <= 1'b1;
          pos_r <= (pos_r == PosW'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Scratch and ring memory
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        if (in_acc) begin
          now_r   <= in_tdata[63:0];
          total_r <= in_tdata[111:64];
        end
      end
      OP_DT: dt_r <= now_r - prev_time_r;
      OP_MUL_LO: begin
        plo_hi_r <= mul_lo[44:32];
        bytes_r  <= total_r[31:0] - prev_total_r[31:0];
      end
      OP_MUL_HI: ticks_r <= mul_hi + {19'd0, plo_hi_r};
      OP_SUM: begin
        rd_bytes_r <= ring_bytes_mem[pos_r];
        rd_ticks_r <= ring_ticks_mem[pos_r];
        rd_vld_r   <= vld_r[pos_r];
      end
      OP_UPDATE: begin
        // zero divisor saturates
        rate_r <= (wts_r == '0) ? '1 : div_quo[RATE_W-1:0];
        ring_bytes_mem[pos_r] <= bytes_r;
        ring_ticks_mem[pos_r] <= ticks_r;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_flag_r <= (op == OP_EMIT);
      out_rate_r <= (op == OP_EMIT) ? rate_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rate_r;
  assign out_tuser  = out_flag_r;

endmodule

FILE: rtl/windowed_throughput_rate_core.sv
// Sliding-window transfer rate. Each input transaction carries a nanosecond
// timestamp and a running byte total; each one yields exactly one output
// transaction. The first transaction after reset only records time and total
// (out_tuser = 0, rate 0). Later ones are dropped with out_tuser = 0 unless
// the elapsed time exceeds min_interval_ns (cfg port, reset 500000000).
// Otherwise elapsed ns become 1/1024 s ticks ((dt*4398)>>32), the byte and
// tick deltas join the window sums, and out_tdata = byte sum / tick sum in
// KiB/s (low 32 bits, all ones when the tick sum is zero), with out_tuser = 1.
// The oldest of WINDOW_DEPTH ring entries then leaves the sums. A rated
// transaction's result is registered after the bit-serial divider finishes,
// and the next input is taken after the result is registered; a first or
// dropped transaction skips the divider. A stalled output delays both.
// One transaction is in flight at a time, and in_tready returns while
// the last result still sits in the output register. Write cfg only when idle.
module windowed_throughput_rate_core #(
  parameter int WINDOW_DEPTH = wtr_pkg::WINDOW_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: [63:0] now_time_ns, [111:64] byte_total
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  // out_tdata: [31:0] rate_kib_per_s
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  // out_tuser: [0] rate_valid
  output logic         out_tuser,
  // min_interval_ns
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import wtr_pkg::*;

  op_t   op;
  stat_t stat;

  // Microcode sequencer: step counter plus control-word ROM.
  wtr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  // Datapath: subtract/multiply/accumulate, ring memory, divider, output reg.
  wtr_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

FILE: rtl/wtr_checker.sv
`include "windowed_throughput_rate_core_macros.svh"

module wtr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  `WTR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output changed while stalled")
  `WTR_ASSERT(a_no_rate_zero, out_tvalid && !out_tuser |-> out_tdata == 32'd0, "nonzero rate on a skipped transaction")
  `WTR_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input taken while a transaction is in flight")
  `WTR_ASSERT_ALWAYS(a_ready_after_reset, !rst_n |=> in_tready, "not ready after reset")

endmodule

bind windowed_throughput_rate_core wtr_checker u_wtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: sim/windowed_throughput_rate_core_tb.sv
`timescale 1ns / 1ps

module windowed_throughput_rate_core_tb;
  import wtr_pkg::*;

  localparam int          DEPTH        = WINDOW_DEPTH_DEF;
  localparam int          IDLE_LIMIT   = 5000;  // cycles with no transaction on either side
  localparam int          SETTLE_CYCLES = 60;
  localparam int          PRINT_CAP    = 40;
  localparam logic [31:0] RATE_SAT     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        rated;
    logic [31:0] kib_per_s;
  } rate_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata   = '0;  // [63:0] now_time_ns, [111:64] byte_total
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;        // [31:0] rate_kib_per_s
  logic         out_tuser;        // [0] rate_valid
  logic         cfg_we     = 1'b0;
  logic [31:0]  cfg_wdata  = '0;

  always #10 clk = ~clk;

  windowed_throughput_rate_core #(
    .WINDOW_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Rate predictor: shadow copy of the window state and the interval register.
  // ---------------------------------------------------------------------------
  logic [31:0] mdl_min_interval;
  logic        mdl_started;
  logic [47:0] mdl_prev_total;
  logic [63:0] mdl_prev_time;
  logic [39:0] mdl_byte_sum;
  logic [31:0] mdl_tick_sum;
  logic [31:0] mdl_ring_bytes [DEPTH];
  logic [31:0] mdl_ring_ticks [DEPTH];
  int unsigned mdl_ring_pos;

  rate_result_t expected_rates[$];

  int  n_errors      = 0;
  int  n_sent        = 0;
  int  n_rated       = 0;
  int  n_saturated   = 0;
  int  n_cfg_writes  = 0;
  int  idle_cycles   = 0;
  int  rx_stall_left = 0;
  bit  gaps_on       = 1'b1;
  bit  rx_stalls_on  = 1'b1;
  rate_result_t want;

  // One transaction in, one result out. Updates the shadow state.
  function automatic rate_result_t predict_rate(logic [63:0] now_ns, logic [47:0] total);
    rate_result_t res;
    logic [63:0]  elapsed;
    logic [63:0]  scaled;
    logic [47:0]  total_delta;
    logic [31:0]  ticks;
    logic [31:0]  bytes;
    logic [39:0]  quotient;
    res = '0;
    // first transaction only seeds the time and byte baselines
    if (!mdl_started) begin
      mdl_started    = 1'b1;
      mdl_prev_total = total;
      mdl_prev_time  = now_ns;
      return res;
    end
    elapsed = now_ns - mdl_prev_time;  // wraps when time runs backwards
    if (elapsed <= {32'd0, mdl_min_interval})
      return res;
    scaled      = elapsed * {32'd0, TICK_MUL};  // kept to 64 bits
    ticks       = scaled[63:32];
    total_delta = total - mdl_prev_total;
    bytes       = total_delta[31:0];
    mdl_prev_total = total;
    mdl_prev_time  = now_ns;
    mdl_byte_sum = mdl_byte_sum + {8'd0, bytes};
    mdl_tick_sum = mdl_tick_sum + ticks;
    if (mdl_tick_sum == '0) begin
      res.kib_per_s = RATE_SAT;
    end else begin
      quotient      = mdl_byte_sum / {8'd0, mdl_tick_sum};
      res.kib_per_s = quotient[31:0];
    end
    res.rated = 1'b1;
    // oldest ring entry leaves the sums, the new deltas take its slot
    mdl_byte_sum = mdl_byte_sum - {8'd0, mdl_ring_bytes[mdl_ring_pos]};
    mdl_tick_sum = mdl_tick_sum - mdl_ring_ticks[mdl_ring_pos];
    mdl_ring_bytes[mdl_ring_pos] = bytes;
    mdl_ring_ticks[mdl_ring_pos] = ticks;
    mdl_ring_pos = (mdl_ring_pos + 1) % DEPTH;
    return res;
  endfunction

  // Mostly short idle stretches, a few long ones.
  function automatic int gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  function automatic int pick_gap();
    if (!gaps_on || $urandom_range(0, 99) < 60) return 0;
    return gap_length();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("ERROR %0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: drive on the falling edge, detect acceptance on the rising edge.
  // Entered and left at a falling edge; tvalid stays high on exit so that
  // back-to-back transactions need no second assignment in one step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [63:0] now_ns, input logic [47:0] total);
    int gap;
    rate_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {total, now_ns};
    do @(posedge clk); while (!in_tready);
    res = predict_rate(now_ns, total);
    expected_rates.push_back(res);
    n_sent++;
    if (res.rated) n_rated++;
    if (res.rated && res.kib_per_s == RATE_SAT) n_saturated++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back.
  // Always waits for a falling edge first so tvalid is never re-driven in this step.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_rates.size() != 0);
  endtask

  // Register write only while idle: nothing in flight once results drain.
  task automatic write_min_interval(input logic [31:0] value);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    mdl_min_interval = value;
    n_cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure in stretches, checked at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_stall_left == 0 && rx_stalls_on && $urandom_range(0, 3) == 0)
      rx_stall_left = gap_length();
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
    if ($urandom_range(0, 399) == 0) rx_stalls_on = !rx_stalls_on;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rates.size() == 0) begin
        report_mismatch("result transaction with none pending", '0,
                        64'({out_tuser, out_tdata}));
      end else begin
        want = expected_rates.pop_front();
        if (out_tuser !== want.rated)
          report_mismatch("rate_valid", 64'(want.rated), 64'(out_tuser));
        if (out_tdata !== want.kib_per_s)
          report_mismatch("rate_kib_per_s", 64'(want.kib_per_s), 64'(out_tdata));
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no transaction.
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results pending",
               IDLE_LIMIT, expected_rates.size());
      $display("windowed_throughput_rate_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset interval: first transaction, dt equal to the limit, dt just above,
  // full-scale byte total and a byte total that runs backwards.
  task automatic test_reset_interval();
    send_sample(64'd0, 48'd0);
    send_sample(64'd500_000_000, 48'd100);
    send_sample(64'd500_000_001, 48'hFFFF_FFFF_FFFF);
    send_sample(64'd1_500_000_000, 48'd0);
    send_sample(64'd1_700_000_000, 48'd5);
  endtask

  // Zero interval: zero-tick deltas fill the ring until the tick sum is zero
  // (divider saturates), then huge byte deltas over one tick overflow the
  // 32-bit quotient. Also time running backwards and both field extremes.
  task automatic test_zero_interval();
    logic [63:0] t;
    logic [47:0] b;
    write_min_interval(32'd0);
    t = mdl_prev_time;
    b = mdl_prev_total;
    for (int i = 0; i < 10; i++) begin
      t = t + 64'd1;
      b = b + 48'd3;
      send_sample(t, b);
    end
    t = t + 64'd976_574;  // exactly one tick
    b = b + 48'hFFFF_FFFF;
    send_sample(t, b);
    for (int i = 0; i < 3; i++) begin
      t = t + 64'd1;
      b = b + 48'hFFFF_FFFF;
      send_sample(t, b);
    end
    send_sample(t - 64'd5, b);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_sample(64'd0, 48'd0);  // wraps to dt = 1
    send_sample(64'd0, 48'd7);  // dt = 0 is never above the limit
  endtask

  // Largest interval: dt equal to 2^32-1 is dropped, 2^32 is rated.
  task automatic test_max_interval();
    write_min_interval(32'hFFFF_FFFF);
    send_sample(64'h0000_0000_FFFF_FFFF, 48'd1);
    send_sample(64'h0000_0001_0000_0000, 48'd2);
    send_sample(64'h8000_0000_0000_0000, 48'h8000_0000_0000);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed progress updates that clear the interval,
  // some inside the interval, some arbitrary noise. Every transaction sent
  // counts toward n_items.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input logic [31:0] min_ns, input int n_items);
    int          counted;
    int unsigned kind;
    int unsigned pick;
    logic [63:0] step;
    logic [47:0] bump;
    logic [63:0] now_ns;
    logic [47:0] total;
    write_min_interval(min_ns);
    counted = 0;
    while (counted < n_items) begin
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (pick < 6)      step = 64'($urandom_range(0, 1_000_000_000));
      else if (pick < 8) step = 64'($urandom_range(0, 2000));
      else               step = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
      pick = $urandom_range(0, 9);
      if (pick < 6)      bump = 48'($urandom_range(0, 1_048_576));
      else if (pick < 9) bump = 48'($urandom);
      else               bump = {16'($urandom), 32'($urandom)};
      if (kind < 72) begin
        now_ns = mdl_prev_time + {32'd0, mdl_min_interval} + 64'd1 + step;
        total  = mdl_prev_total + bump;
      end else if (kind < 86) begin
        now_ns = mdl_prev_time + {32'd0, 32'($urandom_range(0, mdl_min_interval))};
        total  = mdl_prev_total + bump;
      end else begin
        now_ns = {32'($urandom), 32'($urandom)};
        total  = {16'($urandom), 32'($urandom)};
      end
      send_sample(now_ns, total);
      counted++;
      if ($urandom_range(0, 99) == 0) wait_results_drained();
      if ($urandom_range(0, 149) == 0) gaps_on = !gaps_on;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    mdl_min_interval = MIN_INTERVAL_RESET;
    mdl_started      = 1'b0;
    mdl_prev_total   = '0;
    mdl_prev_time    = '0;
    mdl_byte_sum     = '0;
    mdl_tick_sum     = '0;
    mdl_ring_pos     = 0;
    for (int i = 0; i < DEPTH; i++) begin
      mdl_ring_bytes[i] = '0;
      mdl_ring_ticks[i] = '0;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_interval();
    test_zero_interval();
    test_max_interval();

    test_random_traffic(MIN_INTERVAL_RESET, 350);
    test_random_traffic(32'd0, 300);
    test_random_traffic(32'hFFFF_FFFF, 250);
    test_random_traffic(32'($urandom_range(1000, 5_000_000)), 350);
    test_random_traffic(32'($urandom), 350);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_rates.size() != 0)
      report_mismatch("results never delivered", 64'(expected_rates.size()), '0);

    $display("covered %0d input transactions: %0d rated, %0d first or dropped, %0d saturated",
             n_sent, n_rated, n_sent - n_rated, n_saturated);
    $display("interval register written %0d times incl. 0 and all ones; %0d errors",
             n_cfg_writes, n_errors);
    if (n_errors == 0) begin
      $display("windowed_throughput_rate_core: match");
    end else begin
      $display("windowed_throughput_rate_core: mismatch");
    end
    $finish;
  end

endmodule
